[hw/rtl/prq_pkg.sv]
// shared constants, codes and types of the priority ready queue
package prq_pkg;

    localparam int DEPTH  = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // occupancy field value for a full queue, masked to the field width
    localparam logic [CNT_W+OCC_W-1:0] DEPTH_EXT = (CNT_W + OCC_W)'(DEPTH);
    localparam logic [OCC_W-1:0] OCC_FULL = DEPTH_EXT[OCC_W-1:0];

    typedef struct packed {
        logic load;
        logic op;
    } t_cmd;

endpackage

[hw/rtl/prq_req_if.sv]
// request channel: opcode and task entry with valid/ready handshake
interface prq_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [prq_pkg::ID_W-1:0]    task_id;
    logic [prq_pkg::PRIO_W-1:0]  task_priority;

    modport source (output valid, output opcode, output task_id, output task_priority,
                    input ready);
    modport sink   (input valid, input opcode, input task_id, input task_priority,
                    output ready);
endinterface

// result channel: status, removed entry and occupancy with valid/ready handshake
interface prq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [prq_pkg::STAT_W-1:0]  status;
    logic [prq_pkg::ID_W-1:0]    out_id;
    logic [prq_pkg::PRIO_W-1:0]  out_priority;
    logic [prq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output out_id, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input occupancy, output ready);
endinterface

[hw/rtl/prq_ctrl.sv]
// controller: request acceptance and result hold state machine
module prq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output prq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // a held result that is taken this cycle frees the output register
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);

    assign o_cmd.load = accept;
    assign o_cmd.op   = i_in_op;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (accept)           n_state = S_HOLD;
                else if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/prq_datapath.sv]
// datapath: sorted shift-register slots, entry count and result register
module prq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prq_pkg::t_cmd               i_cmd,
    input  logic [prq_pkg::ID_W-1:0]    i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]  i_task_priority,
    output logic [prq_pkg::STAT_W-1:0]  o_status,
    output logic [prq_pkg::ID_W-1:0]    o_out_id,
    output logic [prq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [prq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int D = prq_pkg::DEPTH;

    logic [prq_pkg::ID_W-1:0]   r_ids   [D];
    logic [prq_pkg::PRIO_W-1:0] r_prios [D];
    logic [prq_pkg::ID_W-1:0]   n_ids   [D];
    logic [prq_pkg::PRIO_W-1:0] n_prios [D];
    logic [prq_pkg::CNT_W-1:0]  r_count;
    logic [prq_pkg::CNT_W-1:0]  n_count;

    logic [prq_pkg::STAT_W-1:0] r_status, n_status;
    logic [prq_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic [prq_pkg::PRIO_W-1:0] r_out_prio, n_out_prio;
    logic [prq_pkg::OCC_W-1:0]  r_occ, n_occ;

    logic [D-1:0] ge;
    logic         full;
    logic         empty;
    logic         do_ins;
    logic         do_rem;
    logic [prq_pkg::CNT_W+prq_pkg::OCC_W-1:0] cnt_ext;

    assign full   = (r_count == prq_pkg::CNT_W'(D));
    assign empty  = (r_count == '0);
    assign do_ins = i_cmd.load && (i_cmd.op == prq_pkg::OP_INSERT) && !full;
    assign do_rem = i_cmd.load && (i_cmd.op == prq_pkg::OP_REMOVE) && !empty;

    // slots that stay ahead of the new entry: a prefix of the held entries
    always_comb begin
        for (int i = 0; i < D; i++) begin
            ge[i] = (prq_pkg::CNT_W'(i) < r_count) && (r_prios[i] >= i_task_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_ids[i]   = r_ids[i];
            n_prios[i] = r_prios[i];
        end
        if (do_ins) begin
            if (!ge[0]) begin
                n_ids[0]   = i_task_id;
                n_prios[0] = i_task_priority;
            end
            for (int i = 1; i < D; i++) begin
                if (!ge[i]) begin
                    if (ge[i-1]) begin
                        n_ids[i]   = i_task_id;
                        n_prios[i] = i_task_priority;
                    end else begin
                        n_ids[i]   = r_ids[i-1];
                        n_prios[i] = r_prios[i-1];
                    end
                end
            end
        end else if (do_rem) begin
            for (int i = 0; i < D - 1; i++) begin
                n_ids[i]   = r_ids[i+1];
                n_prios[i] = r_prios[i+1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_ins)      n_count = r_count + prq_pkg::CNT_W'(1);
        else if (do_rem) n_count = r_count - prq_pkg::CNT_W'(1);
    end

    assign cnt_ext = {{prq_pkg::OCC_W{1'b0}}, n_count};

    always_comb begin
        n_status   = prq_pkg::ST_OK;
        n_out_id   = '0;
        n_out_prio = '0;
        n_occ      = cnt_ext[prq_pkg::OCC_W-1:0];
        if (i_cmd.op == prq_pkg::OP_INSERT) begin
            if (full) n_status = prq_pkg::ST_FULL;
        end else if (empty) begin
            n_status = prq_pkg::ST_EMPTY;
        end else begin
            n_out_id   = r_ids[0];
            n_out_prio = r_prios[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < D; i++) begin
            r_ids[i]   <= n_ids[i];
            r_prios[i] <= n_prios[i];
        end
        if (i_cmd.load) begin
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_prio <= n_out_prio;
            r_occ      <= n_occ;
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_occ;

endmodule

[hw/rtl/priority_ready_queue_unit.sv]
// Priority ready queue: up to prq_pkg::DEPTH task entries held in descending priority order,
// equal priorities in arrival order. Each request (insert or remove) yields one result with a
// status, the removed entry and the occupancy after the request. A request is executed in the
// cycle it is accepted and its result is presented from the next cycle, so the block takes one
// request per cycle while results are taken as fast; a held result that is not taken stalls
// further requests, set by the single result register. All slots compare against the new
// priority in parallel, so the cycle count does not depend on occupancy.
module priority_ready_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    prq_req_if.sink           i_req,
    prq_rsp_if.source         o_rsp
);

    prq_pkg::t_cmd cmd;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.opcode),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    prq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_task_id       (i_req.task_id),
        .i_task_priority (i_req.task_priority),
        .o_status        (o_rsp.status),
        .o_out_id        (o_rsp.out_id),
        .o_out_priority  (o_rsp.out_priority),
        .o_occupancy     (o_rsp.occupancy)
    );

endmodule

[hw/rtl/prq_checker.sv]
// port-level checker for the priority ready queue, bound to the top level
module prq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [prq_pkg::STAT_W-1:0]  i_status,
    input logic [prq_pkg::ID_W-1:0]    i_out_id,
    input logic [prq_pkg::PRIO_W-1:0]  i_out_priority,
    input logic [prq_pkg::OCC_W-1:0]   i_occupancy
);

    // status code is always one of the defined ones
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == prq_pkg::ST_OK) || (i_status == prq_pkg::ST_EMPTY)
                        || (i_status == prq_pkg::ST_FULL))
        else $error("undefined status code");

    // failed requests carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != prq_pkg::ST_OK) |-> (i_out_id == '0) && (i_out_priority == '0))
        else $error("failed request returned an entry");

    // full and empty results report matching occupancy
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_status != prq_pkg::ST_FULL) || (i_occupancy == prq_pkg::OCC_FULL))
                     && ((i_status != prq_pkg::ST_EMPTY) || (i_occupancy == '0)))
        else $error("occupancy disagrees with status");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_out_id)
                                       && $stable(i_out_priority) && $stable(i_occupancy))
        else $error("stalled result changed");

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_id       (o_rsp.out_id),
    .i_out_priority (o_rsp.out_priority),
    .i_occupancy    (o_rsp.occupancy)
);
